[rtl/dqsc_pkg.sv]
// Shared types and constants for the dual quadrature speed counter.
`timescale 1ns / 1ps

package dqsc_pkg;

    // Width of every result field.
    localparam int OUT_WIDTH = 32;

    // Request kinds carried by req_type.
    typedef enum logic {
        REQ_PIN  = 1'b0,
        REQ_TICK = 1'b1
    } req_type_t;

    // Edge flags and pin levels of one wheel's encoder.
    typedef struct packed {
        logic a_edge;
        logic b_edge;
        logic a_level;
        logic b_level;
    } wheel_pins_t;

    // Command from the top level to each lane.
    typedef struct packed {
        logic      accept;
        req_type_t kind;
    } lane_cmd_t;

endpackage

[rtl/dqsc_lane.sv]
// One wheel lane: x2 quadrature decode, period counter, speed latch and total.
`timescale 1ns / 1ps

module dqsc_lane #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dqsc_pkg::lane_cmd_t      cmd,
    input  dqsc_pkg::wheel_pins_t    pins,
    output logic [COUNT_WIDTH-1:0]   speed,
    output logic [COUNT_WIDTH-1:0]   total
);

    localparam logic [COUNT_WIDTH-1:0] ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    logic [COUNT_WIDTH-1:0] period_reg, period_next;
    logic [COUNT_WIDTH-1:0] latch_reg,  latch_next;
    logic [COUNT_WIDTH-1:0] total_reg,  total_next;
    logic                   step_up;
    logic                   step_down;

    // A edge wins over B edge; no edge means no step.
    always_comb
    begin
        step_up   = 1'b0;
        step_down = 1'b0;
        if (pins.a_edge)
        begin
            step_up   = pins.b_level;
            step_down = !pins.b_level;
        end
        else if (pins.b_edge)
        begin
            step_up   = !pins.a_level;
            step_down = pins.a_level;
        end
    end

    always_comb
    begin
        period_next = period_reg;
        latch_next  = latch_reg;
        total_next  = total_reg;
        case (cmd.kind)
            dqsc_pkg::REQ_TICK:
            begin
                latch_next  = period_reg;
                period_next = '0;
            end
            dqsc_pkg::REQ_PIN:
            begin
                if (step_up)
                begin
                    period_next = period_reg + ONE;
                    total_next  = total_reg + ONE;
                end
                else if (step_down)
                begin
                    period_next = period_reg - ONE;
                    total_next  = total_reg - ONE;
                end
            end
            default:
            begin
                period_next = period_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            latch_reg  <= '0;
            total_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            period_reg <= period_next;
            latch_reg  <= latch_next;
            total_reg  <= total_next;
        end
    end

    // Post-update values go to the merge stage.
    assign speed = latch_next;
    assign total = total_next;

endmodule

[rtl/dqsc_merge.sv]
// Merge stage: negate and size lane values, hold results in a two-entry output buffer.
`timescale 1ns / 1ps

module dqsc_merge #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [COUNT_WIDTH-1:0]            left_speed_in,
    input  logic [COUNT_WIDTH-1:0]            right_speed_in,
    input  logic [COUNT_WIDTH-1:0]            left_total_in,
    input  logic [COUNT_WIDTH-1:0]            right_total_in,
    output logic                              full,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [dqsc_pkg::OUT_WIDTH-1:0]    left_speed,
    output logic [dqsc_pkg::OUT_WIDTH-1:0]    right_speed,
    output logic [dqsc_pkg::OUT_WIDTH-1:0]    left_position,
    output logic [dqsc_pkg::OUT_WIDTH-1:0]    right_position
);

    localparam int OW = dqsc_pkg::OUT_WIDTH;

    typedef struct packed {
        logic [OW-1:0] l_speed;
        logic [OW-1:0] r_speed;
        logic [OW-1:0] l_pos;
        logic [OW-1:0] r_pos;
    } result_t;

    logic [COUNT_WIDTH-1:0] neg_l_speed;
    logic [COUNT_WIDTH-1:0] neg_r_speed;
    logic [COUNT_WIDTH-1:0] neg_r_total;
    result_t                beat_in;
    result_t                main_reg;
    result_t                skid_reg;
    logic                   main_valid_reg, main_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    logic                   take;
    logic                   load_main_in;
    logic                   load_main_skid;
    logic                   load_skid;

    assign neg_l_speed = '0 - left_speed_in;
    assign neg_r_speed = '0 - right_speed_in;
    assign neg_r_total = '0 - right_total_in;

    // Sign-extend or cut each count to the result width.
    generate
        if (COUNT_WIDTH >= OW)
        begin : g_cut
            assign beat_in.l_speed = neg_l_speed[OW-1:0];
            assign beat_in.r_speed = neg_r_speed[OW-1:0];
            assign beat_in.l_pos   = left_total_in[OW-1:0];
            assign beat_in.r_pos   = neg_r_total[OW-1:0];
        end
        else
        begin : g_ext
            assign beat_in.l_speed = {{(OW-COUNT_WIDTH){neg_l_speed[COUNT_WIDTH-1]}},
                                      neg_l_speed};
            assign beat_in.r_speed = {{(OW-COUNT_WIDTH){neg_r_speed[COUNT_WIDTH-1]}},
                                      neg_r_speed};
            assign beat_in.l_pos   = {{(OW-COUNT_WIDTH){left_total_in[COUNT_WIDTH-1]}},
                                      left_total_in};
            assign beat_in.r_pos   = {{(OW-COUNT_WIDTH){neg_r_total[COUNT_WIDTH-1]}},
                                      neg_r_total};
        end
    endgenerate

    assign take = main_valid_reg && !rsp_stall;

    always_comb
    begin
        load_main_in    = 1'b0;
        load_main_skid  = 1'b0;
        load_skid       = 1'b0;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                // Drain the skid entry; input is stalled meanwhile.
                load_main_skid  = 1'b1;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                load_main_in    = accept;
                main_valid_next = accept;
            end
        end
        else if (accept)
        begin
            // Output is held: park the new beat.
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_main_skid)
        begin
            main_reg <= skid_reg;
        end
        else if (load_main_in)
        begin
            main_reg <= beat_in;
        end
        if (load_skid)
        begin
            skid_reg <= beat_in;
        end
    end

    assign full           = skid_valid_reg;
    assign rsp_valid      = main_valid_reg;
    assign left_speed     = main_reg.l_speed;
    assign right_speed    = main_reg.r_speed;
    assign left_position  = main_reg.l_pos;
    assign right_position = main_reg.r_pos;

endmodule

[rtl/dual_quadrature_speed_counter_core.sv]
// Top level of the dual quadrature speed counter: two wheel lanes and the merge stage.
`timescale 1ns / 1ps

// Decodes the left and right wheel encoders side by side (x2 decoding) and
// returns one result beat per request beat. A pin request (req_type = 0)
// steps each wheel on its own: with the A edge flag set, B low counts down
// and B high counts up; otherwise with the B edge flag set, A low counts up
// and A high counts down; the A flag wins when both are set. Each step moves
// that wheel's period counter and running total. A tick request (req_type =
// 1) copies the period counters into the speed latches and clears them; its
// flags and levels are ignored. Every result carries the negated speeds,
// the left total and the negated right total, all taken after the request's
// update, counters wrapping at COUNT_WIDTH bits and sign-extended or cut to
// 32 bits. Throughput is one beat per clock while req_stall is low; each lane
// updates in the cycle of acceptance, and its result is registered in the main
// entry of a two-entry output buffer, or in the skid entry while the main one
// is held, keeping the request side flowing; req_stall rises only when both
// entries are full. Reset clears all counters and latches at once, no warm-up pass.

module dual_quadrature_speed_counter_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic        left_a_edge,
    input  logic        left_b_edge,
    input  logic        left_a_level,
    input  logic        left_b_level,
    input  logic        right_a_edge,
    input  logic        right_b_edge,
    input  logic        right_a_level,
    input  logic        right_b_level,

    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] left_speed,
    output logic [31:0] right_speed,
    output logic [31:0] left_position,
    output logic [31:0] right_position
);

    dqsc_pkg::lane_cmd_t    cmd;
    dqsc_pkg::wheel_pins_t  left_pins;
    dqsc_pkg::wheel_pins_t  right_pins;
    logic [COUNT_WIDTH-1:0] l_speed;
    logic [COUNT_WIDTH-1:0] r_speed;
    logic [COUNT_WIDTH-1:0] l_total;
    logic [COUNT_WIDTH-1:0] r_total;
    logic                   buf_full;

    // Stall only when the skid entry is occupied.
    assign req_stall  = buf_full;
    assign cmd.accept = req_valid && !buf_full;
    assign cmd.kind   = dqsc_pkg::req_type_t'(req_type);

    assign left_pins  = '{a_edge: left_a_edge, b_edge: left_b_edge,
                          a_level: left_a_level, b_level: left_b_level};
    assign right_pins = '{a_edge: right_a_edge, b_edge: right_b_edge,
                          a_level: right_a_level, b_level: right_b_level};

    // Left and right lanes run the same decoder in parallel.
    dqsc_lane #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane_left (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .pins  (left_pins),
        .speed (l_speed),
        .total (l_total)
    );

    dqsc_lane #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane_right (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .pins  (right_pins),
        .speed (r_speed),
        .total (r_total)
    );

    // Combine lane values into one result beat and buffer it.
    dqsc_merge #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (cmd.accept),
        .left_speed_in  (l_speed),
        .right_speed_in (r_speed),
        .left_total_in  (l_total),
        .right_total_in (r_total),
        .full           (buf_full),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .left_speed     (left_speed),
        .right_speed    (right_speed),
        .left_position  (left_position),
        .right_position (right_position)
    );

endmodule
